>>> src/lfy_pkg.sv
// Shared types and constants for the LCG Fisher-Yates permutation block.
// Holds the microcode word layout, the step program and the sequencer interface.
// No dependencies.
package lfy_pkg;

  localparam int unsigned VAL_W   = 10;   // stored and returned entry width
  localparam int unsigned CNT_W   = 11;   // entry_count register width
  localparam int unsigned IDX_W   = 10;   // entry_index port width
  localparam int unsigned SEED_W  = 64;   // generator width
  localparam int unsigned HALF_W  = SEED_W / 2;
  localparam int unsigned BIT_W   = $clog2(SEED_W);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEED_W-1:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
  localparam logic [SEED_W-1:0] LCG_INC = 64'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  localparam logic [SEED_W-1:0] SEED_RESET  = 64'd1;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;

  typedef logic [3:0] step_t;

  // program addresses
  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_BINIT   = 4'd1;
  localparam step_t ST_FILL    = 4'd2;
  localparam step_t ST_SETI    = 4'd3;
  localparam step_t ST_MUL0    = 4'd4;
  localparam step_t ST_MUL1    = 4'd5;
  localparam step_t ST_MUL2    = 4'd6;
  localparam step_t ST_MODINIT = 4'd7;
  localparam step_t ST_MODSTEP = 4'd8;
  localparam step_t ST_RDI     = 4'd9;
  localparam step_t ST_RDJ     = 4'd10;
  localparam step_t ST_WRI     = 4'd11;
  localparam step_t ST_WRJ     = 4'd12;
  localparam step_t ST_FIN     = 4'd13;
  localparam step_t ST_READ    = 4'd14;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_FILL,
    OP_SETI,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MODINIT,
    OP_MODSTEP,
    OP_RDI,
    OP_RDJ,
    OP_WRI,
    OP_WRJ,
    OP_DONE_BUILD,
    OP_DONE_READ
  } op_e;

  // jump when the condition holds, else next step; DISPATCH holds until start
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_N_ZERO,
    COND_N_SMALL,
    COND_FILL_MORE,
    COND_MOD_MORE,
    COND_I_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic cmd;
    logic n_zero;
    logic n_small;
    logic fill_more;
    logic mod_more;
    logic i_more;
  } seq_status_t;

  typedef struct packed {
    op_e  op;
    logic busy;
  } seq_ctrl_t;

  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    unique case (addr)
      ST_IDLE:    w = '{OP_NOP,        COND_DISPATCH,  ST_IDLE};
      ST_BINIT:   w = '{OP_INIT,       COND_N_ZERO,    ST_FIN};
      ST_FILL:    w = '{OP_FILL,       COND_FILL_MORE, ST_FILL};
      ST_SETI:    w = '{OP_SETI,       COND_N_SMALL,   ST_FIN};
      ST_MUL0:    w = '{OP_MUL0,       COND_NEXT,      ST_IDLE};
      ST_MUL1:    w = '{OP_MUL1,       COND_NEXT,      ST_IDLE};
      ST_MUL2:    w = '{OP_MUL2,       COND_NEXT,      ST_IDLE};
      ST_MODINIT: w = '{OP_MODINIT,    COND_NEXT,      ST_IDLE};
      ST_MODSTEP: w = '{OP_MODSTEP,    COND_MOD_MORE,  ST_MODSTEP};
      ST_RDI:     w = '{OP_RDI,        COND_NEXT,      ST_IDLE};
      ST_RDJ:     w = '{OP_RDJ,        COND_NEXT,      ST_IDLE};
      ST_WRI:     w = '{OP_WRI,        COND_NEXT,      ST_IDLE};
      ST_WRJ:     w = '{OP_WRJ,        COND_I_MORE,    ST_MUL0};
      ST_FIN:     w = '{OP_DONE_BUILD, COND_ALWAYS,    ST_IDLE};
      ST_READ:    w = '{OP_DONE_READ,  COND_ALWAYS,    ST_IDLE};
      default:    w = '{OP_NOP,        COND_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> src/lfy_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on lfy_pkg for the program and the control/status structs.
module lfy_sequencer import lfy_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output seq_ctrl_t   ctrl_o
);

  step_t  upc_q, upc_d;
  ucode_t word;

  assign word = ucode_rom(upc_q);

  always_comb begin
    upc_d = upc_q + step_t'(1);
    unique case (word.cond)
      COND_NEXT:      upc_d = upc_q + step_t'(1);
      COND_ALWAYS:    upc_d = word.target;
      COND_DISPATCH: begin
        if (status_i.start) begin
          upc_d = status_i.cmd ? ST_READ : ST_BINIT;
        end else begin
          upc_d = upc_q;
        end
      end
      COND_N_ZERO:    if (status_i.n_zero)    upc_d = word.target;
      COND_N_SMALL:   if (status_i.n_small)   upc_d = word.target;
      COND_FILL_MORE: if (status_i.fill_more) upc_d = word.target;
      COND_MOD_MORE:  if (status_i.mod_more)  upc_d = word.target;
      COND_I_MORE:    if (status_i.i_more)    upc_d = word.target;
      default:        upc_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.busy = (upc_q != ST_IDLE);

endmodule

>>> src/lcg_fisher_yates_permutation.sv
// Timing: a read strobes done_o in the cycle after acceptance; a build of n >= 1
// entries strobes after an init step, n fill steps, a set-up step and n-1 swaps.
// Throughput: one transaction at a time; start is taken again the cycle after
// done_o. Each swap is 3 multiply steps, 1 + 64 divider steps and 4 table steps.
// Reset (async, active low): sequencer idle, seed = 1, entry_count = 1024;
// table contents stay undefined until the first build. Receiver cannot stall.
module lcg_fisher_yates_permutation import lfy_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  // result channel
  output logic                 done_o,
  output logic [VAL_W-1:0]     entry_value_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SEED_W-1:0]    cfg_wdata_i
);

  // AW addresses the table, CW holds a count up to MAX_ENTRIES
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NW = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned IW = (AW > IDX_W) ? AW + 1 : IDX_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SEED_W-1:0] seed_q;
  logic [CNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SEED) begin
        seed_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_COUNT) begin
        count_q <= cfg_wdata_i[CNT_W-1:0];
      end
    end
  end

  // effective entry count, saturated to the table depth
  logic [NW-1:0] cnt_ext;
  logic [NW-1:0] cnt_sat;
  logic [CW-1:0] n_eff;

  assign cnt_ext = NW'(count_q);
  assign cnt_sat = (cnt_ext > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : cnt_ext;
  assign n_eff   = CW'(cnt_sat);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  seq_status_t status;
  seq_ctrl_t   ctrl;
  logic        accept;

  lfy_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign busy   = ctrl.busy;
  assign accept = start && !ctrl.busy;

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic [SEED_W-1:0] state_q;    // generator state
  logic [SEED_W-1:0] acc_q;      // partial product accumulator
  logic [AW-1:0]     p_q;        // fill pointer
  logic [AW-1:0]     i_q;        // swap position, counts down to 1
  logic [BIT_W-1:0]  k_q;        // dividend bit pointer
  logic [CW-1:0]     r_q;        // remainder; low AW bits are j after division
  logic [VAL_W-1:0]  held_q;     // entry i during a swap
  logic [VAL_W-1:0]  rdata_q;    // registered table read
  logic              idx_ok_q;   // read index inside the table

  // one shared 32x32 multiplier for the three partial products of state*MUL
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [SEED_W-1:0] prod;

  always_comb begin
    mul_a = state_q[HALF_W-1:0];
    mul_b = LCG_MUL[HALF_W-1:0];
    unique case (ctrl.op)
      OP_MUL1: mul_a = state_q[SEED_W-1:HALF_W];
      OP_MUL2: mul_b = LCG_MUL[SEED_W-1:HALF_W];
      default: ;
    endcase
  end

  assign prod = SEED_W'(mul_a) * SEED_W'(mul_b);

  // restoring division step: shift in one dividend bit, subtract if it fits
  logic [CW-1:0] divisor;
  logic [CW:0]   r_shift;
  logic [CW:0]   r_sub;

  assign divisor = CW'(i_q) + CW'(1);
  assign r_shift = {r_q, state_q[k_q]};
  assign r_sub   = r_shift - {1'b0, divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      p_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (ctrl.op)
        OP_INIT: begin
          state_q <= seed_q;
          p_q     <= '0;
        end
        OP_FILL:    p_q <= p_q + AW'(1);
        OP_SETI:    i_q <= AW'(n_eff - CW'(1));
        // low half of the MUL1 term was already folded into acc_q
        OP_MUL2: begin
          state_q <= {acc_q[SEED_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};
        end
        OP_MODINIT: k_q <= BIT_W'(SEED_W - 1);
        OP_MODSTEP: k_q <= k_q - BIT_W'(1);
        OP_WRJ:     i_q <= i_q - AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      // lo*lo cannot overflow 64 bits with the increment added
      OP_MUL0: acc_q <= prod + LCG_INC;
      OP_MUL1: acc_q[SEED_W-1:HALF_W] <= acc_q[SEED_W-1:HALF_W] + prod[HALF_W-1:0];
      OP_MODINIT: r_q <= '0;
      OP_MODSTEP: r_q <= r_sub[CW] ? r_shift[CW-1:0] : r_sub[CW-1:0];
      OP_RDJ:  held_q <= rdata_q;
      default: ;
    endcase
    if (accept) begin
      idx_ok_q <= (IW'(entry_index_i) < IW'(MAX_ENTRIES));
    end
  end

  // ---------------------------------------------------------------------------
  // Permutation table: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] table_mem [MAX_ENTRIES];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_q;
    mem_wdata = VAL_W'(p_q);
    mem_raddr = i_q;
    unique case (ctrl.op)
      OP_NOP:  mem_raddr = AW'(entry_index_i);
      OP_FILL: mem_we = 1'b1;
      OP_RDJ:  mem_raddr = r_q[AW-1:0];
      OP_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
      end
      OP_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = r_q[AW-1:0];
        mem_wdata = held_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= table_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Status back to the sequencer and result outputs
  // ---------------------------------------------------------------------------
  assign status.start     = start;
  assign status.cmd       = cmd_i;
  assign status.n_zero    = (n_eff == '0);
  assign status.n_small   = (n_eff < CW'(2));
  assign status.fill_more = ((CW'(p_q) + CW'(1)) < n_eff);
  assign status.mod_more  = (k_q != '0);
  assign status.i_more    = (i_q != AW'(1));

  assign done_o        = (ctrl.op == OP_DONE_BUILD) || (ctrl.op == OP_DONE_READ);
  assign entry_value_o = ((ctrl.op == OP_DONE_READ) && idx_ok_q) ? rdata_q : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a transaction always leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not make the block busy");

  // one strobe per transaction, then back to idle
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  // after the division, j stays within 0..i
  a_j_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_RDI) |-> (r_q < divisor))
    else $error("swap partner outside 0..i");

  // the swap loop never reaches position zero
  a_i_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_WRJ) |-> (i_q != '0))
    else $error("swap at position zero");

endmodule

>>> dv/tb_lcg_fisher_yates_permutation.sv
// Self-checking testbench for lcg_fisher_yates_permutation: directed and random
// build/read transactions, checked against an in-bench shadow of the table.
// Depends on lfy_pkg and the lcg_fisher_yates_permutation RTL.
module tb_lcg_fisher_yates_permutation;
  import lfy_pkg::*;

  // command encodings as seen on cmd_i
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // register slots with no register behind them; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 2'd3;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam logic [SEED_W-1:0] GEN_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [SEED_W-1:0] GEN_INC  = 64'd1;
  localparam logic [SEED_W-1:0] SEED_ONES = '1;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] index;
    bit               hold;   // wait for all results before issuing
  } perm_cmd_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 cmd_i = CMD_BUILD;
  logic [IDX_W-1:0]     entry_index_i = '0;
  logic                 done_o;
  logic [VAL_W-1:0]     entry_value_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SEED;
  logic [SEED_W-1:0]    cfg_wdata_i = '0;

  lcg_fisher_yates_permutation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .done_o        (done_o),
    .entry_value_o (entry_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow of the block: table, generator and register copies.
  logic [VAL_W-1:0]  perm_shadow [TABLE_DEPTH];
  logic [SEED_W-1:0] gen_state = '0;
  logic [SEED_W-1:0] seed_cfg = SEED_RESET;
  logic [CNT_W-1:0]  count_cfg = COUNT_RESET;

  perm_cmd_t        pending_cmds[$];
  logic [VAL_W-1:0] expected_values[$];
  int unsigned      issued_count = 0;
  int unsigned      retired_count = 0;
  int unsigned      error_count = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      built_span = 0;  // positions written by some build so far

  // Applies one transaction to the shadow and returns the value the block
  // must answer: the stored entry for a read, zero for a build.
  function automatic logic [VAL_W-1:0] apply_command(input logic c,
                                                     input logic [IDX_W-1:0] idx);
    int n;
    int j;
    logic [VAL_W-1:0]  held;
    logic [SEED_W-1:0] span;
    if (c == CMD_READ) return perm_shadow[idx];
    n = (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_cfg);
    for (int p = 0; p < n; p++) perm_shadow[p] = VAL_W'(p);
    gen_state = seed_cfg;
    // Fisher-Yates from the top down; fewer than two entries stay identity
    for (int p = n - 1; p >= 1; p--) begin
      gen_state = gen_state * GEN_MULT + GEN_INC;
      span = SEED_W'(p) + 64'd1;
      j = int'(gen_state % span);
      held = perm_shadow[p];
      perm_shadow[p] = perm_shadow[j];
      perm_shadow[j] = held;
    end
    return '0;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: when the port is free, pops the next pending command unless it idles
  // at random or a held command must wait. The expectation is computed at the
  // accepting edge, so it sees exactly the table state the block sees.
  always @(posedge clk_i or negedge rst_ni) begin
    perm_cmd_t item;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= CMD_BUILD;
      entry_index_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_values.push_back(apply_command(cmd_i, entry_index_i));
        issued_count <= issued_count + 1;
      end
      if (!start || !busy) begin
        // a held command waits until the port is empty and all results are in
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            !(pending_cmds[0].hold && (start || retired_count < issued_count))) begin
          item = pending_cmds.pop_front();
          start <= 1'b1;
          cmd_i <= item.cmd;
          entry_index_i <= item.index;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe retires the oldest expectation.
  always @(posedge clk_i) begin
    logic [VAL_W-1:0] want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_values.size() == 0) begin
        $error("unexpected transaction: entry_value actual %0d", entry_value_o);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (entry_value_o !== want) begin
          $error("entry_value mismatch: expected %0d actual %0d", want, entry_value_o);
          error_count++;
        end
      end
      retired_count <= retired_count + 1;
    end
  end

  // Register write; only called while the block is idle, so the shadow copy
  // can be updated right away.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SEED:  seed_cfg = data;
      CFG_COUNT: count_cfg = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic c, input logic [IDX_W-1:0] idx, input bit hold);
    perm_cmd_t item;
    item.cmd = c;
    item.index = idx;
    item.hold = hold;
    pending_cmds.push_back(item);
    if (c == CMD_BUILD && count_cfg > built_span)
      built_span = (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : count_cfg;
  endtask

  // Checked at the falling edge so that all edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || retired_count < issued_count);
  endtask

  // Reads only ever touch positions some earlier build has written.
  function automatic logic [IDX_W-1:0] any_built_index();
    return IDX_W'($urandom_range(built_span - 1));
  endfunction

  initial begin
    logic [SEED_W-1:0] seed_val;
    logic [CNT_W-1:0]  count_val;
    int unsigned       n_items;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: first build runs on reset values (seed 1, full table), then
    // reads at index zero, the top entry, both alternating-bit patterns and 512.
    sender_idle_pct = 0;
    queue_cmd(CMD_BUILD, IDX_W'($urandom), 1'b0);
    queue_cmd(CMD_READ, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd1023, 1'b0);
    queue_cmd(CMD_READ, 10'h155, 1'b0);
    queue_cmd(CMD_READ, 10'h2AA, 1'b1);
    queue_cmd(CMD_READ, 10'd512, 1'b0);
    wait_idle();

    // count above the table size saturates; all-ones seed
    cfg_write(CFG_SEED, SEED_ONES);
    cfg_write(CFG_COUNT, 64'd2047);
    @(negedge clk_i);
    queue_cmd(CMD_BUILD, 10'd1023, 1'b0);
    queue_cmd(CMD_READ, 10'd1023, 1'b0);
    queue_cmd(CMD_READ, 10'd0, 1'b0);
    wait_idle();

    // two entries, zero seed; position 2 keeps the older build's value
    cfg_write(CFG_SEED, 64'd0);
    cfg_write(CFG_COUNT, 64'd2);
    @(negedge clk_i);
    queue_cmd(CMD_BUILD, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd1, 1'b0);
    queue_cmd(CMD_READ, 10'd2, 1'b0);
    wait_idle();

    // single entry: identity, no swap
    cfg_write(CFG_SEED, 64'hA5A5_5A5A_0F0F_F0F0);
    cfg_write(CFG_COUNT, 64'd1);
    @(negedge clk_i);
    queue_cmd(CMD_BUILD, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd0, 1'b0);
    wait_idle();

    // zero entries writes nothing; unmapped register slots must not stick
    cfg_write(CFG_COUNT, 64'd0);
    cfg_write(CFG_SPARE0, {$urandom, $urandom});
    cfg_write(CFG_SPARE1, {$urandom, $urandom});
    @(negedge clk_i);
    queue_cmd(CMD_BUILD, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd0, 1'b0);
    queue_cmd(CMD_READ, 10'd7, 1'b0);
    wait_idle();

    // Random phases: each sets seed and count, builds, then mostly reads.
    // Sender idling rotates between none, heavy and light.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(9))
        0: seed_val = '0;
        1: seed_val = SEED_ONES;
        default: seed_val = {$urandom, $urandom};
      endcase
      if (ph == 3) count_val = 11'd1024;
      else if (ph == 7) count_val = CNT_W'($urandom_range(65, 1023));
      else if ($urandom_range(9) == 0) count_val = CNT_W'($urandom_range(1, 2));
      else count_val = CNT_W'($urandom_range(3, 32));
      cfg_write(CFG_SEED, seed_val);
      cfg_write(CFG_COUNT, SEED_W'(count_val));
      @(negedge clk_i);
      case (ph % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 79;
        default: sender_idle_pct = 9;
      endcase
      queue_cmd(CMD_BUILD, IDX_W'($urandom), 1'b0);
      n_items = $urandom_range(8, 11);
      for (int k = 0; k < n_items; k++) begin
        // rebuilds only on small tables to keep the run short
        if (count_cfg <= 64 && $urandom_range(99) < 15)
          queue_cmd(CMD_BUILD, IDX_W'($urandom), $urandom_range(99) < 8);
        else
          queue_cmd(CMD_READ, any_built_index(), $urandom_range(99) < 8);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (expected_values.size() != 0) begin
      $error("%0d transactions never returned a result", expected_values.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit: a few full-size builds plus many small ones stay far below this.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
src/lfy_pkg.sv
src/lfy_sequencer.sv
src/lcg_fisher_yates_permutation.sv
dv/tb_lcg_fisher_yates_permutation.sv
